>>> src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register map, multiply-reduce unit request types and the
// single remainder step used by the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Field widths.
  localparam int BASE_W   = 31;
  localparam int EXP_W    = 32;
  localparam int MOD_W    = 31;
  localparam int RESULT_W = 31;

  // Default number of exponent bits that are scanned.
  localparam int EXP_WIDTH_DEFAULT = 32;

  // Configuration register map.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS = 2'd0;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Multiply-reduce unit: the product is 2*MOD_W bits wide. The top bits
  // above MM_LO_W already form a residue, the low MM_LO_W bits are shifted
  // into it MM_STEPS bits per cycle.
  localparam int PROD_W    = 2 * MOD_W;
  localparam int MM_LO_W   = 32;
  localparam int MM_HI_W   = PROD_W - MM_LO_W;
  localparam int MM_STEPS  = 2;
  localparam int MM_CYCLES = MM_LO_W / MM_STEPS;
  localparam int MM_CNT_W  = $clog2(MM_CYCLES);

  // Request into the shared multiply-reduce unit.
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
    logic [MOD_W-1:0] modulus;
  } mm_req_t;

  // Response from the shared multiply-reduce unit.
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] residue;
  } mm_rsp_t;

  // One restoring remainder step: shift a product bit into a residue that is
  // below the modulus, and subtract the modulus once if needed.
  function automatic logic [MOD_W-1:0] red_step(
    input logic [MOD_W-1:0] rem,
    input logic             din,
    input logic [MOD_W-1:0] modulus
  );
    logic [MOD_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[MOD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/mexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

>>> src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Shared modular multiply unit
// Multiplies two operands and registers the product, then reduces the product
// modulo the modulus by restoring remainder steps, two product bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod import mexp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire mm_req_t req,
  output mm_rsp_t      rsp
);

  typedef enum logic [1:0] {
    MM_IDLE = 2'b01,
    MM_RED  = 2'b10
  } mm_state_t;

  mm_state_t           state;
  logic [MM_CNT_W-1:0] cnt;
  logic                done;
  logic [MOD_W-1:0]    rem;
  logic [MM_LO_W-1:0]  lo;
  logic [MOD_W-1:0]    modulus;
  logic [PROD_W-1:0]   prod;
  logic [MOD_W-1:0]    rem_next;

  // Full product of the two operands.
  assign prod = req.a * req.b;

  // Two chained remainder steps on the top bits of the low word.
  always_comb begin
    rem_next = rem;
    for (int k = 0; k < MM_STEPS; k++) begin
      rem_next = red_step(rem_next, lo[MM_LO_W-1-k], modulus);
    end
  end

  // Control: idle until a start, then reduce until the low word is used up.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MM_IDLE: begin
          if (req.start) begin
            state <= MM_RED;
            cnt   <= '0;
          end
        end
        MM_RED: begin
          cnt <= cnt + 1'b1;
          if (cnt == MM_CNT_W'(MM_CYCLES - 1)) begin
            state <= MM_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= MM_IDLE;
        end
      endcase
    end
  end

  // Datapath: load the product, then shift the low word into the residue.
  always_ff @(posedge clk) begin
    if (state == MM_IDLE && req.start) begin
      rem     <= {{(MOD_W - MM_HI_W){1'b0}}, prod[PROD_W-1:MM_LO_W]};
      lo      <= prod[MM_LO_W-1:0];
      modulus <= req.modulus;
    end else if (state == MM_RED) begin
      rem <= rem_next;
      lo  <= lo << MM_STEPS;
    end
  end

  assign rsp.done    = done;
  assign rsp.residue = rem;

endmodule

`default_nettype wire

>>> src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_ch carries a base and an exponent; it is taken when valid
// and ready are both high, and ready is high only while the block is idle.
// One result per request leaves on out_ch through an output register, so a
// new request is taken while the previous result still waits for the sink.
// The modulus is written through the APB port at byte address 0, and the
// user must write it only while the block is idle: the block does not enforce
// this. Reset loads 1000000007. Every modular multiply goes through one shared
// multiply-reduce unit, which loads the product and then reduces it two
// product bits at a time. The base is reduced first; then each scanned
// exponent bit below the highest set bit costs one square, plus one multiply
// when the bit is set, and the highest set bit costs only its multiply, where
// the scan stops. A modulus below 2 gives 0 without a multiply. Ready returns
// in the cycle the result becomes valid. If the sink stalls, the finished
// result is held in the block until the output register frees.
// Reset is synchronous and returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation import mexp_pkg::*; #(
  parameter int EXP_WIDTH = EXP_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mexp_in_if.sink                    in_ch,
  mexp_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Only the exponent bits present on the port can be set.
  localparam int SCAN_W = (EXP_WIDTH < EXP_W) ? EXP_WIDTH : EXP_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RBASE = 6'b000010,
    S_STEP  = 6'b000100,
    S_WACC  = 6'b001000,
    S_WSQR  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [MOD_W-1:0]    modulus;
  logic [MOD_W-1:0]    acc;
  logic [MOD_W-1:0]    pw;
  logic [SCAN_W-1:0]   exp_bits;
  logic [SCAN_W-1:0]   exp_rest;
  logic                out_valid;
  logic [RESULT_W-1:0] out_power_mod;
  logic                accept;
  mm_req_t             mm_req;
  mm_rsp_t             mm_rsp;

  assign accept   = in_ch.valid && in_ch.ready;
  assign exp_rest = exp_bits >> 1;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MODULUS) begin
      modulus <= pwdata[MOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MODULUS) begin
      prdata = {{(APB_DATA_W - MOD_W){1'b0}}, modulus};
    end
  end

  // Shared unit instance.
  mexp_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // Operand selection for the shared unit.
  always_comb begin
    mm_req         = '0;
    mm_req.modulus = modulus;
    case (state)
      S_IDLE: begin
        // Reduce the base by multiplying it by one.
        mm_req.start = accept && modulus >= MOD_W'(2);
        mm_req.a     = in_ch.base;
        mm_req.b     = MOD_W'(1);
      end
      S_STEP: begin
        mm_req.start = (exp_bits != '0);
        mm_req.a     = exp_bits[0] ? acc : pw;
        mm_req.b     = pw;
      end
      S_WACC: begin
        mm_req.start = mm_rsp.done && (exp_rest != '0);
        mm_req.a     = pw;
        mm_req.b     = pw;
      end
      default: begin
        mm_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer over the exponent bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (modulus < MOD_W'(2)) ? S_DONE : S_RBASE;
          end
        end
        S_RBASE: begin
          if (mm_rsp.done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (exp_bits == '0) begin
            state <= S_DONE;
          end else if (exp_bits[0]) begin
            state <= S_WACC;
          end else begin
            state <= S_WSQR;
          end
        end
        S_WACC: begin
          if (mm_rsp.done) begin
            state <= (exp_rest == '0) ? S_DONE : S_WSQR;
          end
        end
        S_WSQR: begin
          if (mm_rsp.done) begin
            state <= S_STEP;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers: running result, current power and remaining exponent.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          acc      <= (modulus < MOD_W'(2)) ? '0 : MOD_W'(1);
          exp_bits <= in_ch.exponent[SCAN_W-1:0];
        end
      end
      S_RBASE: begin
        if (mm_rsp.done) begin
          pw <= mm_rsp.residue;
        end
      end
      S_WACC: begin
        if (mm_rsp.done) begin
          acc <= mm_rsp.residue;
        end
      end
      S_WSQR: begin
        if (mm_rsp.done) begin
          pw       <= mm_rsp.residue;
          exp_bits <= exp_rest;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register toward the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_power_mod <= acc;
    end
  end

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.power_mod = out_power_mod;

endmodule

`default_nettype wire

>>> test/tb_modular_exponentiation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base/exponent requests under several modulus settings and handshake
// pacings, predicts each power with an independent square-and-multiply
// model, and compares every returned residue in order.
// ----------------------------------------------------------------------------

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_TAIL = 1200;
  localparam int SCAN_BITS = EXP_WIDTH_DEFAULT;
  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
  localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mexp_in_if in_ch ();
  mexp_out_if out_ch ();

  // Testbench copy of the modulus register and the in-flight predictions.
  logic [MOD_W-1:0] modulus_setting = MODULUS_RESET;
  logic [RESULT_W-1:0] pending_powers[$];

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int moduli_written = 0;
  int mismatches = 0;
  int cycle_count = 0;

  modular_exponentiation dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-time guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result sink: ready drops at random according to the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Right-to-left square-and-multiply over the scanned exponent bits.
  function automatic logic [RESULT_W-1:0] expected_power(input logic [BASE_W-1:0] b,
                                                          input logic [EXP_W-1:0] e,
                                                          input logic [MOD_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    int i;
    if (m < 2) begin
      return '0;
    end
    mm = 64'(m);
    sq = 64'(b) % mm;
    acc = 64'd1;
    for (i = 0; i < SCAN_BITS; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % mm;
      end
      sq = (sq * sq) % mm;
    end
    return acc[RESULT_W-1:0];
  endfunction

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    logic [RESULT_W-1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_powers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_ch.power_mod);
      end else begin
        want = pending_powers.pop_front();
        results_checked++;
        if (out_ch.power_mod !== want) begin
          mismatches++;
          $display("%0t: power_mod mismatch, expected %0d, actual %0d", $time, want,
                   out_ch.power_mod);
        end
      end
    end
  end

  // Present one request, with a random idle gap first, and record its result.
  task automatic send_request(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.base <= b;
    in_ch.exponent <= e;
    do @(posedge clk); while (!in_ch.ready);
    pending_powers.push_back(expected_power(b, e, modulus_setting));
    requests_sent++;
  endtask

  // Stop sending and wait until every predicted result has been returned.
  // With nothing outstanding the request line is already low.
  task automatic wait_all_results();
    if (pending_powers.size() != 0) begin
      in_ch.valid <= 1'b0;
    end
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // APB write of the modulus, done only once the block has gone idle.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    wait_all_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MODULUS;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    modulus_setting = value;
    moduli_written++;
  endtask

  // Random request: bases lean toward the modulus edges, and exponents are
  // mostly short so that long scans stay a minority.
  task automatic send_random_request();
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0] e;
    int w;
    int pick;
    case ($urandom_range(9))
      0: b = '0;
      1: b = BASE_W'(1);
      2: b = BASE_W'(modulus_setting - 1'b1);
      3: b = BASE_W'(modulus_setting);
      default: b = BASE_W'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 8) begin
      w = $urandom_range(0, 2);
    end else if (pick < 60) begin
      w = $urandom_range(1, 8);
    end else if (pick < 85) begin
      w = $urandom_range(9, 16);
    end else begin
      w = $urandom_range(17, 32);
    end
    e = $urandom & ~(32'hFFFF_FFFF << w);
    send_request(b, e);
  endtask

  // Field extremes at the reset modulus, including exponent zero.
  task automatic test_reset_modulus();
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    send_request('0, '0);
    send_request('0, EXP_W'(1));
    send_request(BASE_MAX, '0);
    send_request(BASE_MAX, EXP_MAX);
    send_request('0, EXP_MAX);
    send_request(BASE_W'(1), EXP_MAX);
    send_request(BASE_W'(2), EXP_W'(10));
    send_request(BASE_W'(MODULUS_RESET), EXP_W'(5));
    send_request(BASE_W'(MODULUS_RESET - 1'b1), EXP_W'(2));
    send_request(BASE_W'(3), 32'h8000_0000);
    wait_all_results();
  endtask

  // Largest and smallest legal moduli, then modulus one and zero.
  task automatic test_modulus_extremes();
    write_modulus(MOD_MAX);
    send_request(BASE_MAX, EXP_W'(7));
    send_request(BASE_W'(MOD_MAX - 1'b1), EXP_MAX);
    send_request(BASE_W'(12345), 32'hAAAA_AAAA);
    write_modulus(MOD_W'(2));
    send_request(BASE_W'(3), EXP_W'(5));
    send_request(BASE_W'(2), EXP_W'(3));
    write_modulus(MOD_W'(1));
    send_request(BASE_W'(5), '0);
    send_request(BASE_W'(7), EXP_W'(9));
    write_modulus('0);
    send_request(BASE_W'(5), EXP_W'(3));
    send_request('0, '0);
    wait_all_results();
  endtask

  // The sender holds off mid-stream until the block has drained completely.
  task automatic test_pause_until_drained();
    int n;
    write_modulus(MODULUS_RESET);
    sender_idle_pct = 0;
    sink_stall_pct = 50;
    for (n = 0; n < 10; n++) begin
      send_random_request();
    end
    wait_all_results();
    for (n = 0; n < 10; n++) begin
      send_random_request();
    end
    wait_all_results();
  endtask

  // Random requests over several modulus settings under one pacing.
  task automatic test_random_pacing(input int idle_pct, input int stall_pct,
                                    input logic [MOD_W-1:0] first_modulus);
    int s;
    int n;
    logic [MOD_W-1:0] m;
    for (s = 0; s < 4; s++) begin
      if (s == 0) begin
        m = first_modulus;
      end else begin
        case ($urandom_range(3))
          0: m = MOD_W'($urandom_range(2, 1000));
          1: m = MOD_W'($urandom_range(2, 65536));
          default: m = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
        endcase
      end
      write_modulus(m);
      sender_idle_pct = idle_pct;
      sink_stall_pct = stall_pct;
      for (n = 0; n < 115; n++) begin
        send_random_request();
      end
    end
    wait_all_results();
  endtask

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.base = '0;
    in_ch.exponent = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_modulus();
    test_modulus_extremes();
    test_pause_until_drained();
    test_random_pacing(0, 0, MOD_MAX);
    test_random_pacing(75, 0, MOD_W'(2));
    test_random_pacing(0, 75, MOD_W'(32'h4000_0000));
    test_random_pacing(11, 11, MODULUS_RESET);

    wait_all_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Covered %0d requests across %0d modulus writes, four pacing phases.",
             requests_sent, moduli_written);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
